// ===== rtl/nws_pkg.sv =====
// Package for the nonlinear widescreen stretch unit.
// Shared constants and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package nws_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH = 2048;
  localparam int DEF_FRACTION_BITS    = 16;
  localparam int MIN_WIDTH            = 16;
  localparam int RESET_WIDTH          = 1440;
  localparam int RESULT_CAP           = 3;
  localparam int COL_W                = 12;
  localparam int CH_W                 = 8;
  // floor(x/3) == (x*RECIP3) >> RECIP_SHIFT for x below 32768
  localparam int RECIP3               = 21846;
  localparam int RECIP_SHIFT          = 16;
  localparam int RECIP_W              = 15;

  typedef struct packed {
    logic load_in;   // latch the accepted source pixel
    logic capture;   // hold the evaluated result, advance output column
    logic push;      // move the held result into the output register
    logic last;      // pushed result is the last of this pixel
    logic finish;    // end of pixel: update previous pixel and columns
    logic mul1;      // square the warp offset
    logic mul2;      // scale and load the divider
    logic div_step;  // one quotient bit
    logic pos_load;  // write the new sample position
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic hold_valid;
    logic out_free;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/nws_datapath.sv =====
// Datapath of the stretch unit: width derived terms, sample position
// calculation with a bit-serial divider, interpolation and output register.
// Depends on nws_pkg.
`default_nettype none
module nws_datapath #(
  parameter int MAX_SOURCE_WIDTH = nws_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int FRACTION_BITS    = nws_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire nws_pkg::cmd_t          cmd,
  output nws_pkg::status_t            st,
  input  wire logic                   cfg_fire,
  input  wire logic [11:0]            cfg_data,
  input  wire logic [7:0]             red_in,
  input  wire logic [7:0]             green_in,
  input  wire logic [7:0]             blue_in,
  input  wire logic                   row_end_in,
  input  wire logic                   frame_end_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  red_out,
  output logic [7:0]                  green_out,
  output logic [7:0]                  blue_out,
  output logic [11:0]                 out_column,
  output logic                        row_end_out,
  output logic                        frame_end_out,
  output logic                        run_last
);
  import nws_pkg::*;

  localparam int FB  = FRACTION_BITS;
  localparam int WW  = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int LW  = $clog2(MAX_SOURCE_WIDTH * 4 / 3 + 1);
  localparam int QW  = LW + FB;
  localparam int NW  = 3 * LW + FB;
  localparam int PW  = LW + FB + 1;
  localparam int PSW = LW + FB + 2;
  localparam int AW  = LW + 1;
  localparam int XW  = (AW > COL_W + 1) ? AW : COL_W + 1;
  localparam int CW  = $clog2(QW + 1);
  localparam int MW  = WW + 2 + RECIP_W;
  localparam int BW  = CH_W + FB + 2;

  // configuration and derived terms
  logic [WW-1:0]   width_r;
  logic [LW-1:0]   len_r, lout_r, dist_r;
  logic [2*LW-1:0] lsq_r;
  logic [MW-1:0]   len_prod;
  logic [WW-1:0]   width_nxt;
  logic [12:0]     cfg_ext;

  assign cfg_ext = {1'b0, cfg_data};
  always_comb begin
    if (cfg_ext < 13'(MIN_WIDTH)) begin
      width_nxt = WW'(MIN_WIDTH);
    end else if (cfg_ext > 13'(MAX_SOURCE_WIDTH)) begin
      width_nxt = WW'(MAX_SOURCE_WIDTH);
    end else begin
      width_nxt = WW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WW'(RESET_WIDTH);
    end else if (cfg_fire) begin
      width_r <= width_nxt;
    end
  end

  assign len_prod = MW'({width_r, 2'b00}) * MW'(RECIP3);

  // derived terms recompute continuously; len_r and lout_r follow width_r, then dist_r and lsq_r follow len_r
  always_ff @(posedge clk) begin
    len_r  <= len_prod[RECIP_SHIFT +: LW];
    lout_r <= {len_prod[RECIP_SHIFT+1 +: LW-1], 1'b0};
    dist_r <= (len_r - LW'(width_r)) >> 1;
    lsq_r  <= (2*LW)'(len_r) * (2*LW)'(len_r);
  end

  // pixel and column state
  logic [23:0]      cur_r, prev_r;
  logic             close_r, frame_r;
  logic [COL_W-1:0] scol_r;
  logic [LW-1:0]    ocol_r;
  logic [PW-1:0]    pos_r;

  // evaluate the current output column
  logic [AW-1:0] a0_raw, a0, a1;
  logic [FB-1:0] frac;
  logic [23:0]   pix0, pix1;
  logic [XW-1:0] s_x, a0_x, a1_x;
  logic [7:0]    blend_c [3];

  assign a0_raw = pos_r[PW-1:FB];
  assign s_x    = XW'(scol_r);
  always_comb begin
    if (a0_raw >= AW'(width_r) - AW'(1)) begin
      a0   = AW'(width_r) - AW'(1);
      frac = '0;
    end else begin
      a0   = a0_raw;
      frac = pos_r[FB-1:0];
    end
    a1 = a0 + AW'(frac != '0);
  end
  assign a0_x = XW'(a0);
  assign a1_x = XW'(a1);
  assign pix0 = (a0_x == s_x) ? cur_r : prev_r;
  assign pix1 = (a1_x == s_x) ? cur_r : prev_r;

  always_comb begin
    logic [BW-1:0] acc;
    for (int c = 0; c < 3; c++) begin
      acc = BW'(pix0[8*c +: 8]) * BW'((FB+1)'(1) << FB) - BW'(pix0[8*c +: 8]) * BW'(frac)
          + BW'(pix1[8*c +: 8]) * BW'(frac);
      blend_c[c] = acc[FB +: 8];
    end
  end

  assign st.can_emit = (ocol_r < lout_r) && (s_x < XW'(width_r)) && (a1_x <= s_x);

  // held result
  logic       hold_v_r;
  logic [7:0] hold_r [3];
  logic [11:0] hold_col_r;
  logic       hold_re_r;

  assign st.hold_valid = hold_v_r;
  assign st.out_free   = !out_valid || out_ready;

  // position calculation
  logic             neg_r;
  logic [LW-1:0]    esq_base;
  logic [2*LW-1:0]  esq_r;
  logic signed [PSW-1:0] base_r;
  logic [2*LW-1:0]  rem_r;
  logic [QW-1:0]    numlo_r, quo_r;
  logic [CW-1:0]    cnt_r;
  logic signed [LW+1:0] eoff;
  logic [NW-1:0]    num;
  logic [2*LW:0]    trial;
  logic signed [PSW-1:0] p_new;

  assign eoff     = $signed({1'b0, ocol_r, 1'b0}) - $signed({2'b00, len_r});
  assign esq_base = eoff[LW+1] ? LW'(-eoff) : LW'(eoff);
  assign num      = NW'(esq_r * (2*LW)'(dist_r)) << FB;
  assign trial    = {rem_r, numlo_r[QW-1]};
  assign st.div_last = (cnt_r == CW'(QW - 1));

  always_comb begin
    if (neg_r) begin
      p_new = base_r + $signed(PSW'(quo_r));
    end else begin
      p_new = base_r - $signed(PSW'(quo_r)) - $signed(PSW'(rem_r != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      neg_r  <= eoff[LW+1];
      esq_r  <= (2*LW)'(esq_base) * (2*LW)'(esq_base);
      base_r <= ($signed(PSW'(ocol_r)) - $signed(PSW'(dist_r))) <<< FB;
    end
    if (cmd.mul2) begin
      rem_r   <= num[NW-1:QW];
      numlo_r <= num[QW-1:0];
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      if (trial >= (2*LW+1)'(lsq_r)) begin
        rem_r <= (2*LW)'(trial - (2*LW+1)'(lsq_r));
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= trial[2*LW-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      numlo_r <= {numlo_r[QW-2:0], 1'b0};
      cnt_r   <= cnt_r + CW'(1);
    end
    if (cmd.load_in) begin
      cur_r   <= {blue_in, green_in, red_in};
      close_r <= row_end_in || frame_end_in;
      frame_r <= frame_end_in;
    end
    if (cmd.capture) begin
      for (int c = 0; c < 3; c++) hold_r[c] <= blend_c[c];
      hold_col_r <= 12'(ocol_r);
      hold_re_r  <= (ocol_r == lout_r - LW'(1));
    end
    if (cmd.push) begin
      red_out       <= hold_r[0];
      green_out     <= hold_r[1];
      blue_out      <= hold_r[2];
      out_column    <= hold_col_r;
      row_end_out   <= hold_re_r || (cmd.last && close_r);
      frame_end_out <= cmd.last && (hold_re_r || close_r) && frame_r;
      run_last      <= cmd.last;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      scol_r    <= '0;
      ocol_r    <= '0;
      pos_r     <= '0;
      hold_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.capture) begin
        hold_v_r <= 1'b1;
      end else if (cmd.push) begin
        hold_v_r <= 1'b0;
      end
      if (cmd.capture) begin
        ocol_r <= ocol_r + LW'(1);
      end
      if (cmd.pos_load) begin
        pos_r <= p_new[PSW-1] ? '0 : p_new[PW-1:0];
      end
      if (cmd.finish) begin
        prev_r <= cur_r;
        if (close_r) begin
          scol_r <= '0;
          ocol_r <= '0;
          pos_r  <= '0;
        end else if (scol_r != {COL_W{1'b1}}) begin
          scol_r <= scol_r + COL_W'(1);
        end
      end
      if (cfg_fire) begin
        scol_r <= '0;
        ocol_r <= '0;
        pos_r  <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nws_ctrl.sv =====
// Controller of the stretch unit: sequences evaluation, result hand-off,
// position calculation and end of pixel. Depends on nws_pkg.
`default_nettype none
module nws_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             cfg_fire,
  input  wire nws_pkg::status_t st,
  output nws_pkg::cmd_t         cmd
);
  import nws_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_POS  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] n_r, n_nxt;
  logic [1:0] wait_r, wait_nxt;
  logic       emit;

  assign in_ready = (state_r == S_IDLE) && (wait_r == 2'd0);
  assign emit     = st.can_emit && (n_r < 2'(RESULT_CAP));

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    n_nxt     = n_r;
    wait_nxt  = (wait_r != 2'd0) ? wait_r - 2'd1 : wait_r;
    if (cfg_fire) wait_nxt = 2'd2;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          n_nxt       = 2'd0;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!st.hold_valid || st.out_free) begin
          cmd.push = st.hold_valid;
          cmd.last = !emit;
          if (emit) begin
            cmd.capture = 1'b1;
            n_nxt       = n_r + 2'd1;
            state_nxt   = S_MUL1;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_POS;
      end
      S_POS: begin
        cmd.pos_load = 1'b1;
        state_nxt    = S_EVAL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= 2'd0;
      wait_r  <= 2'd2;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      wait_r  <= wait_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nonlinear_widescreen_stretch_unit.sv =====
// Top level of the nonlinear widescreen stretch unit.
// Instantiates nws_ctrl and nws_datapath; depends on nws_pkg.
//
// Widens each RGB row from source_width pixels to floor(W*4/3) made even,
// with a quadratic warp that stretches the edges most. One source pixel is
// taken per transfer and yields 0 to 3 output pixels. Each result needs
// the bit-serial divider that computes the next sample position, one
// quotient bit a cycle. Results wait in an output register, so the next
// pixel can be taken while the last result is still pending. A width write
// restarts the row; inputs are held off after it while the width terms
// settle.
`default_nettype none
module nonlinear_widescreen_stretch_unit #(
  parameter int MAX_SOURCE_WIDTH = nws_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int FRACTION_BITS    = nws_pkg::DEF_FRACTION_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic        in_row_end_in,
  input  wire logic        in_frame_end_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic [11:0]      out_column,
  output logic             out_row_end_out,
  output logic             out_frame_end_out,
  output logic             out_run_last
);
  import nws_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  nws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_fire (cfg_fire),
    .st       (st),
    .cmd      (cmd)
  );

  nws_datapath #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .cfg_fire      (cfg_fire),
    .cfg_data      (cfg_data),
    .red_in        (in_red_in),
    .green_in      (in_green_in),
    .blue_in       (in_blue_in),
    .row_end_in    (in_row_end_in),
    .frame_end_in  (in_frame_end_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red_out       (out_red_out),
    .green_out     (out_green_out),
    .blue_out      (out_blue_out),
    .out_column    (out_column),
    .row_end_out   (out_row_end_out),
    .frame_end_out (out_frame_end_out),
    .run_last      (out_run_last)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for nonlinear_widescreen_stretch_unit.
// Predicts every output pixel of the warped row stretch and compares field by field;
// depends only on the RTL and nws_pkg.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB        = nws_pkg::DEF_FRACTION_BITS;
  localparam int MAX_W     = nws_pkg::DEF_MAX_SOURCE_WIDTH;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic        row_end;
    logic        frame_end;
    logic        run_last;
  } stretched_px_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic        in_row_end_in = 1'b0, in_frame_end_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red_out, out_green_out, out_blue_out;
  logic [11:0] out_column;
  logic        out_row_end_out, out_frame_end_out, out_run_last;

  // predictor state
  int unsigned   src_width;
  logic [23:0]   last_pixel;
  int unsigned   src_col;
  int unsigned   dst_col;
  longint        dst_pos;
  stretched_px_t pending_px[$];

  int errors = 0;
  int progress = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  always #2 clk = ~clk;

  nonlinear_widescreen_stretch_unit dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_ready, .in_red_in, .in_green_in, .in_blue_in,
    .in_row_end_in, .in_frame_end_in,
    .out_valid, .out_ready, .out_red_out, .out_green_out, .out_blue_out,
    .out_column, .out_row_end_out, .out_frame_end_out, .out_run_last
  );

  // Exact fixed point sample position of an output column
  function automatic longint warp_position(int unsigned tx);
    longint w, l, d, e, num, den, q, r, p;
    w = src_width;
    l = (w * 4) / 3;
    d = (l - w) / 2;
    e = 2 * longint'(tx) - l;
    num = (e * e * d) << FB;
    den = l * l;
    q = num / den;
    r = num % den;
    p = (longint'(tx) - d) * (longint'(1) << FB);
    p = (e < 0) ? p + q : p - q - ((r != 0) ? 1 : 0);
    return (p < 0) ? 0 : p;
  endfunction

  function automatic logic [7:0] lerp_channel(logic [7:0] c0, logic [7:0] c1, longint t);
    longint acc;
    acc = longint'(c0) * ((longint'(1) << FB) - t) + longint'(c1) * t;
    return 8'(acc >> FB);
  endfunction

  function automatic void restart_row();
    src_col = 0;
    dst_col = 0;
    dst_pos = 0;
  endfunction

  function automatic void apply_width(logic [11:0] value);
    int unsigned v;
    v = value;
    if (v < nws_pkg::MIN_WIDTH) v = nws_pkg::MIN_WIDTH;
    if (v > MAX_W) v = MAX_W;
    src_width = v;
    restart_row();
  endfunction

  // Queue the output pixels that one accepted source pixel releases
  function automatic void predict_pixel(logic [23:0] cur, bit row_end, bit frame_end);
    int unsigned   lout, n;
    longint        a0, a1, t;
    logic [23:0]   p0, p1;
    stretched_px_t px;
    bit            closing;
    closing = row_end | frame_end;
    lout = ((src_width * 4) / 3) & ~1;
    n = 0;
    while (n < nws_pkg::RESULT_CAP && dst_col < lout && src_col < src_width) begin
      a0 = dst_pos >> FB;
      t = dst_pos & ((longint'(1) << FB) - 1);
      if (a0 >= src_width - 1) begin
        a0 = src_width - 1;
        t = 0;
      end
      a1 = (t != 0) ? a0 + 1 : a0;
      if (a1 > src_col) break;
      p0 = (a0 == src_col) ? cur : last_pixel;
      p1 = (a1 == src_col) ? cur : last_pixel;
      px.red = lerp_channel(p0[7:0], p1[7:0], t);
      px.green = lerp_channel(p0[15:8], p1[15:8], t);
      px.blue = lerp_channel(p0[23:16], p1[23:16], t);
      px.column = 12'(dst_col);
      px.row_end = (dst_col == lout - 1);
      px.frame_end = 1'b0;
      px.run_last = 1'b0;
      pending_px.push_back(px);
      dst_col++;
      dst_pos = warp_position(dst_col);
      n++;
    end
    if (n > 0) begin
      px = pending_px.pop_back();
      px.run_last = 1'b1;
      if (closing) px.row_end = 1'b1;
      px.frame_end = px.row_end & frame_end;
      pending_px.push_back(px);
    end
    last_pixel = cur;
    if (closing) restart_row();
    else if (src_col < 4095) src_col++;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Send one source pixel; valid stays high into the next call when no gap follows
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            bit row_end, bit frame_end);
    int  gap;
    bit  rdy;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_red_in = r;
    in_green_in = g;
    in_blue_in = b;
    in_row_end_in = row_end;
    in_frame_end_in = frame_end;
    forever begin
      #1 rdy = in_ready;
      @(posedge clk);
      if (rdy) break;
      @(negedge clk);
    end
    predict_pixel({b, g, r}, row_end, frame_end);
    progress++;
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_valid = 1'b0;
    wait (pending_px.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Width register write, only with the block idle
  task automatic write_width(logic [11:0] value);
    bit rdy;
    quiesce();
    cfg_valid = 1'b1;
    cfg_data = value;
    forever begin
      #1 rdy = cfg_ready;
      @(posedge clk);
      if (rdy) break;
      @(negedge clk);
    end
    apply_width(value);
    progress++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_row(int unsigned len, bit frame_end);
    for (int unsigned i = 0; i < len; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                 i == len - 1, frame_end && i == len - 1);
  endtask

  // Result side: stall runs of random length, sample at the rising edge
  always begin
    bit            take;
    int            stall_left;
    stretched_px_t got, want;
    @(negedge clk);
    if (stalls_on && stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      stall_left = (stalls_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
    #1 take = out_valid && out_ready;
    got = '{out_red_out, out_green_out, out_blue_out, out_column,
            out_row_end_out, out_frame_end_out, out_run_last};
    @(posedge clk);
    if (take) begin
      progress++;
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected pixel column", got.column, -1);
      end else begin
        want = pending_px.pop_front();
        if (got.red != want.red) report_mismatch("red", got.red, want.red);
        if (got.green != want.green) report_mismatch("green", got.green, want.green);
        if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.column != want.column) report_mismatch("column", got.column, want.column);
        if (got.row_end != want.row_end)
          report_mismatch("row_end", got.row_end, want.row_end);
        if (got.frame_end != want.frame_end)
          report_mismatch("frame_end", got.frame_end, want.frame_end);
        if (got.run_last != want.run_last)
          report_mismatch("run_last", got.run_last, want.run_last);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always begin
    int idle_cycles, seen;
    idle_cycles = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (progress != seen) begin
        seen = progress;
        idle_cycles = 0;
      end else if (++idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Default width straight out of reset, row closed early
  task automatic test_reset_width();
    send_pixel(8'h00, 8'hFF, 8'h55, 0, 0);
    send_pixel(8'hFF, 8'h00, 8'hAA, 0, 0);
    send_pixel(8'h12, 8'h34, 8'h56, 0, 0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1, 0);
  endtask

  // Smallest width, full row of extremes ending the frame
  task automatic test_min_width_row();
    write_width(12'd0);
    for (int i = 0; i < 16; i++)
      send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h00 : 8'hFF, 8'(i * 17),
                 i == 15, i == 15);
  endtask

  // Row longer than the width, then an oversize width write
  task automatic test_long_row_and_max();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    write_width(12'd16);
    send_row(20, 0);
    write_width(12'hFFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 0, 0);
    send_pixel(8'h00, 8'h00, 8'h00, 0, 1);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Mostly well formed rows at small widths, some broken ones
  task automatic test_random_rows();
    int sent, len, kind;
    sent = 0;
    while (sent < 75) begin
      if ($urandom_range(0, 3) == 0) write_width(12'($urandom_range(16, 40)));
      gaps_on = $urandom_range(0, 4) != 0;
      stalls_on = $urandom_range(0, 4) != 0;
      kind = $urandom_range(0, 9);
      if (kind < 7) len = src_width;
      else if (kind < 9) len = $urandom_range(1, src_width + 4);
      else len = 0;
      if (len > 0) begin
        send_row(len, $urandom_range(0, 3) == 0);
        sent += len;
      end else begin
        // noise: random flags
        for (int i = 0; i < 6; i++)
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                     $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
        sent += 6;
      end
    end
    write_width(12'd2048);
    send_row(3, 1);
  endtask

  initial begin
    src_width = nws_pkg::RESET_WIDTH;
    last_pixel = '0;
    restart_row();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_reset_width();
    test_min_width_row();
    test_long_row_and_max();
    test_random_rows();
    quiesce();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
